// ===== sv/crc32c_fnv1a_hash_engine_core_macros.svh =====
// Assertion macros for the CRC32C / FNV-1a hash engine.
// Uses the clk and rst_n names of the module that expands them.
// Define ASSERT_OFF to compile the checks out.
`ifndef CRC32C_FNV1A_HASH_ENGINE_CORE_MACROS_SVH
`define CRC32C_FNV1A_HASH_ENGINE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge out of reset
`define C32_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Condition must never be seen at a rising clock edge out of reset
`define C32_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define C32_ASSERT(lbl, prop, msg)
`define C32_NEVER(lbl, cond, msg)
`endif

`endif

// ===== sv/c32fnv_pkg.sv =====
// Shared types, constants and CRC helper functions for the hash engine.
// No dependencies; used by the interfaces' users and all engine modules.
package c32fnv_pkg;

  // Mode register codes
  localparam logic MODE_CRC = 1'b0;
  localparam logic MODE_FNV = 1'b1;

  // Input func codes
  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_WORD = 2'd1;
  localparam logic [1:0] FUNC_NONE = 2'd2;

  // CRC32C (reflected Castagnoli)
  localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

  // FNV-1a 64: prime = 2^40 + 0x1B3
  localparam logic [63:0] FNV_BASIS       = 64'hCBF2_9CE4_8422_2325;
  localparam logic [8:0]  FNV_PRIME_LO    = 9'h1B3;
  localparam int unsigned FNV_PRIME_SHIFT = 40;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_BYTE = 2'd1,
    OP_WORD = 2'd2
  } op_t;

  // Queue entry; byte items already have data zero-extended from bits 7:0
  typedef struct packed {
    logic [63:0] data;
    op_t         op;
    logic        last;
  } q_entry_t;

  typedef logic [31:0] col8_t  [8];
  typedef logic [31:0] col32_t [32];
  typedef logic [31:0] col64_t [64];

  // Bit-serial CRC, only called at elaboration to build the column tables
  function automatic logic [31:0] crc_serial(input logic [31:0] c, input logic [63:0] d,
                                             input int nbits);
    logic [31:0] r;
    logic        lsb;
    r = c;
    for (int i = 0; i < 64; i++) begin
      if (i < nbits) begin
        lsb = r[0] ^ d[i];
        r   = (r >> 1) ^ (CRC_POLY & {32{lsb}});
      end
    end
    return r;
  endfunction

  function automatic col32_t crc_state_cols(input int nbits);
    col32_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = crc_serial(32'h1 << i, 64'h0, nbits);
    end
    return t;
  endfunction

  function automatic col8_t crc_byte_data_cols();
    col8_t t;
    for (int j = 0; j < 8; j++) begin
      t[j] = crc_serial(32'h0, 64'h1 << j, 8);
    end
    return t;
  endfunction

  function automatic col64_t crc_word_data_cols();
    col64_t t;
    for (int j = 0; j < 64; j++) begin
      t[j] = crc_serial(32'h0, 64'h1 << j, 64);
    end
    return t;
  endfunction

  // CRC is linear: next state is an XOR of columns picked by state and data bits
  localparam col32_t CRC_BYTE_STATE = crc_state_cols(8);
  localparam col8_t  CRC_BYTE_DATA  = crc_byte_data_cols();
  localparam col32_t CRC_WORD_STATE = crc_state_cols(64);
  localparam col64_t CRC_WORD_DATA  = crc_word_data_cols();

  function automatic logic [31:0] crc_byte_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      r = r ^ (CRC_BYTE_STATE[i] & {32{c[i]}});
    end
    for (int j = 0; j < 8; j++) begin
      r = r ^ (CRC_BYTE_DATA[j] & {32{b[j]}});
    end
    return r;
  endfunction

  function automatic logic [31:0] crc_word_step(input logic [31:0] c, input logic [63:0] d);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      r = r ^ (CRC_WORD_STATE[i] & {32{c[i]}});
    end
    for (int j = 0; j < 64; j++) begin
      r = r ^ (CRC_WORD_DATA[j] & {32{d[j]}});
    end
    return r;
  endfunction

endpackage

// ===== sv/c32fnv_if.sv =====
// Valid/ready channel interfaces of the hash engine: input, result, config.
// No dependencies.
interface c32fnv_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data;
  logic [1:0]  func;
  logic        last;
  modport source (output valid, data, func, last, input ready);
  modport sink   (input valid, data, func, last, output ready);
endinterface

interface c32fnv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash;
  modport source (output valid, hash, input ready);
  modport sink   (input valid, hash, output ready);
endinterface

interface c32fnv_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, mode, input ready);
  modport sink   (input valid, mode, output ready);
endinterface

// ===== sv/c32fnv_front.sv =====
// Front end: accepts input transactions, classifies func, and queues them.
// Depends on c32fnv_pkg and c32fnv_in_if.
module c32fnv_front import c32fnv_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  c32fnv_in_if.sink      in_if,
  output q_entry_t       head,
  output logic           head_valid,
  input  logic           pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push;
  q_entry_t        entry;

  // Classify the incoming item; unused func code absorbs no data
  always_comb begin
    entry.last = in_if.last;
    entry.data = in_if.data;
    unique case (in_if.func)
      FUNC_BYTE: begin
        entry.op   = OP_BYTE;
        entry.data = {56'h0, in_if.data[7:0]};
      end
      FUNC_WORD: entry.op = OP_WORD;
      default:   entry.op = OP_NONE;
    endcase
  end

  assign in_if.ready = (count_r < CW'(DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign head_valid  = (count_r != '0);
  assign head        = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ===== sv/c32fnv_back.sv =====
// Back end: applies queued steps to the running hash and registers results.
// Depends on c32fnv_pkg and c32fnv_out_if.
module c32fnv_back import c32fnv_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mode,
  input  q_entry_t       head,
  input  logic           head_valid,
  output logic           pop,
  c32fnv_out_if.source   out_if
);

  logic [63:0] hash_r, hash_nxt;
  logic        fresh_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r;
  logic [63:0] base;
  logic [31:0] crc_nxt;
  logic [63:0] fnv_x;
  logic [63:0] fnv_prod;
  logic [31:0] result;

  // Take the queue head whenever the output register is free or draining
  assign pop = head_valid && (!out_valid_r || out_if.ready);

  // Start of message loads the mode's initial value
  always_comb begin
    if (fresh_r) begin
      base = (mode == MODE_CRC) ? {32'h0, CRC_INIT} : FNV_BASIS;
    end else begin
      base = hash_r;
    end
  end

  // CRC32C step
  always_comb begin
    case (head.op)
      OP_BYTE: crc_nxt = crc_byte_step(base[31:0], head.data[7:0]);
      OP_WORD: crc_nxt = crc_word_step(base[31:0], head.data);
      default: crc_nxt = base[31:0];
    endcase
  end

  // FNV-1a step: multiply by 2^40 + 0x1B3 modulo 2^64
  assign fnv_x    = base ^ head.data;
  assign fnv_prod = (fnv_x << FNV_PRIME_SHIFT) + (fnv_x * 64'(FNV_PRIME_LO));

  always_comb begin
    if (mode == MODE_CRC) begin
      hash_nxt = {32'h0, crc_nxt};
      result   = crc_nxt ^ CRC_XOROUT;
    end else begin
      hash_nxt = (head.op == OP_NONE) ? base : fnv_prod;
      result   = hash_nxt[63:32] ^ hash_nxt[31:0];
    end
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && head.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= '0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        hash_r  <= hash_nxt;
        fresh_r <= head.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_hash_r <= result;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.hash  = out_hash_r;

endmodule

// ===== sv/crc32c_fnv1a_hash_engine_core.sv =====
// CRC32C / FNV-1a-64 message hash engine.
// Input items (in_if) carry data, func and last; a transaction completes when
// valid and ready are both high at a rising edge of clk. func selects one byte
// (bits 7:0), one 8-byte little-endian word, or no data. The transaction with
// last set produces one result transaction on out_if holding the 32-bit hash;
// the next item starts a fresh message.
// cfg_if writes the mode bit (0 CRC32C, 1 FNV-1a folded to 32 bits); it is
// always ready and should only be written while no message is in flight.
// A last item accepted on in_if goes through the front queue into the output
// register. Throughput: one item per clock while out_if does not stall, set by
// the combinational CRC XOR network and the back end's constant multiply.
// The front queue (QUEUE_DEPTH entries) keeps in_if.ready high while a
// result waits; if out_if stalls, the queue fills and then in_if.ready drops.
// Reset (rst_n, synchronous, active low) empties the queue and the output
// register, clears mode to CRC32C and marks the next item as a message start.
// Depends on c32fnv_pkg, the channel interfaces and the macros header.
`include "crc32c_fnv1a_hash_engine_core_macros.svh"

module crc32c_fnv1a_hash_engine_core import c32fnv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  c32fnv_in_if.sink     in_if,
  c32fnv_out_if.source  out_if,
  c32fnv_cfg_if.sink    cfg_if
);

  logic     mode_r;
  q_entry_t q_head;
  logic     q_valid;
  logic     q_pop;

  // Mode register
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CRC;
    end else if (cfg_if.valid && cfg_if.ready) begin
      mode_r <= cfg_if.mode;
    end
  end

  c32fnv_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop)
  );

  c32fnv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .out_if     (out_if)
  );

  // Checks
  `C32_NEVER(a_pop_empty, q_pop && !q_valid, "back end popped an empty queue")
  `C32_NEVER(a_full_empty, !in_if.ready && !q_valid, "queue refuses input while empty")
  `C32_ASSERT(a_last_result, q_pop && q_head.last |=> out_if.valid, "last item gave no result")

endmodule
